// ----- src/lfu_pkg.sv -----
package lfu_pkg;

  // cache geometry
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;
  localparam int COUNT_W    = 32;
  localparam int STAMP_W    = 32;

  // slot index and slot count widths
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  // external field widths
  localparam int FIELD_W   = 64;
  localparam int CAP_RAW_W = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // capacity after reset, saturated to the slot count
  localparam int CAP_RESET = (16 > ENTRIES) ? ENTRIES : 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  // register index (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_W-1:0]    count;
    logic [STAMP_W-1:0]    stamp;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic              wr_key;
    logic              wr_value;
    slot_t             data;
  } slot_wr_t;

  typedef struct packed {
    logic                  match;
    logic [SLOT_W-1:0]     match_idx;
    logic [COUNT_W-1:0]    match_count;
    logic [VALUE_BITS-1:0] match_value;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [CNT_W-1:0]      used;
    logic                  victim_found;
    logic [SLOT_W-1:0]     victim_idx;
    logic [KEY_BITS-1:0]   victim_key;
  } scan_res_t;

endpackage

// ----- src/lfu_cache_lru_tiebreak.sv -----
// A result is on the ports, with done, once the scan, compare and commit of an access are over.
// A new access is not accepted while busy; start is taken again in the cycle after done. The
// slot store's single read port is scanned one slot per cycle, a compare stage follows the last
// read, a commit state writes back, and a register stage drives the results.
// done is high for exactly one cycle; the receiver cannot stall it.
// Reset (rst, synchronous): cache empty, stamp counter zero, capacity = min(16, ENTRIES).
module lfu_cache_lru_tiebreak (
  input  logic                          clk,
  input  logic                          rst,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [lfu_pkg::FIELD_W-1:0]   key,
  input  logic [lfu_pkg::FIELD_W-1:0]   write_value,
  // result side
  output logic                          done,
  output logic                          hit,
  output logic [lfu_pkg::FIELD_W-1:0]   read_value,
  output logic                          evicted,
  output logic [lfu_pkg::FIELD_W-1:0]   evicted_key,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfu_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfu_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import lfu_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]      scan_ptr;
  logic                  issue_done;
  logic                  proc_ok;
  logic [SLOT_W-1:0]     proc_idx;
  logic                  rd_en;
  slot_t                 rd_data;

  logic                  req_is_set;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  logic [CNT_W-1:0]      capacity;
  logic [CNT_W-1:0]      cap_new;
  logic [ENTRIES-1:0]    slot_valid;
  logic [STAMP_W-1:0]    stamp_counter;

  logic                  cfg_wr;
  logic                  accept;
  logic                  scan_last;

  scan_res_t             res;
  slot_wr_t              wr;
  logic                  ins_en;
  logic [SLOT_W-1:0]     ins_idx;

  logic                  hit_next;
  logic [FIELD_W-1:0]    read_value_next;
  logic                  evicted_next;
  logic [FIELD_W-1:0]    evicted_key_next;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign scan_last = proc_ok && (proc_idx == SLOT_W'(ENTRIES - 1));

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_comb begin
    if (32'(pwdata[CAP_RAW_W-1:0]) > 32'(ENTRIES)) begin
      cap_new = CNT_W'(ENTRIES);
    end else begin
      cap_new = CNT_W'(pwdata[CAP_RAW_W-1:0]);
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = PDATA_W'(capacity);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(CAP_RESET);
    end else if (cfg_wr) begin
      capacity <= cap_new;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_is_set <= (req_type == REQ_SET);
      req_key    <= key[KEY_BITS-1:0];
      req_value  <= write_value[VALUE_BITS-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan address sequencing and read pipeline flags
  assign rd_en = (state == ST_SCAN) && !issue_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr   <= '0;
      issue_done <= 1'b0;
      proc_ok    <= 1'b0;
      proc_idx   <= '0;
    end else begin
      proc_ok  <= rd_en;
      proc_idx <= scan_ptr[SLOT_W-1:0];
      if (accept) begin
        scan_ptr   <= '0;
        issue_done <= 1'b0;
      end else if (rd_en) begin
        scan_ptr <= scan_ptr + CNT_W'(1);
        if (scan_ptr == CNT_W'(ENTRIES - 1)) begin
          issue_done <= 1'b1;
        end
      end
    end
  end

  lfu_slot_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (scan_ptr[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  lfu_scan_unit u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (accept),
    .proc      (proc_ok),
    .proc_idx  (proc_idx),
    .slot_ok   (slot_valid[proc_idx]),
    .rd        (rd_data),
    .req_key   (req_key),
    .capacity  (capacity),
    .stamp_now (stamp_counter),
    .res       (res)
  );

  // next state and commit decisions
  always_comb begin
    state_next       = state;
    wr               = '0;
    ins_en           = 1'b0;
    ins_idx          = res.free_idx;
    hit_next         = 1'b0;
    read_value_next  = '0;
    evicted_next     = 1'b0;
    evicted_key_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_next      = ST_RESP;
        wr.data.key     = req_key;
        wr.data.value   = req_value;
        wr.data.count   = COUNT_W'(1);
        wr.data.stamp   = stamp_counter;
        if (capacity != '0) begin
          if (!req_is_set) begin
            // get: bump the count unless saturated
            if (res.match) begin
              hit_next        = 1'b1;
              read_value_next = FIELD_W'(res.match_value);
              if (res.match_count != COUNT_MAX) begin
                wr.en         = 1'b1;
                wr.addr       = res.match_idx;
                wr.data.count = res.match_count + COUNT_W'(1);
              end
            end
          end else if (res.match) begin
            // set of a present key: update in place, count restarts
            hit_next    = 1'b1;
            wr.en       = 1'b1;
            wr.addr     = res.match_idx;
            wr.wr_value = 1'b1;
          end else begin
            // set of a new key: evict when full, else take the first free slot
            if (res.used >= capacity) begin
              ins_en           = res.victim_found;
              ins_idx          = res.victim_idx;
              evicted_next     = res.victim_found;
              evicted_key_next = res.victim_found ? FIELD_W'(res.victim_key) : '0;
            end else begin
              ins_en  = res.free_found;
              ins_idx = res.free_idx;
            end
            wr.en       = ins_en;
            wr.addr     = ins_idx;
            wr.wr_key   = 1'b1;
            wr.wr_value = 1'b1;
          end
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // valid bits: cleared at and above the new capacity on a write, set on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cfg_wr) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (32'(i) >= 32'(cap_new)) begin
          slot_valid[i] <= 1'b0;
        end
      end
    end else if (ins_en) begin
      slot_valid[ins_idx] <= 1'b1;
    end
  end

  // entry stamp advances with every count entry
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
    end else if (wr.en) begin
      stamp_counter <= stamp_counter + STAMP_W'(1);
    end
  end

  // result registers and transfer strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_COMMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COMMIT) begin
      hit         <= hit_next;
      read_value  <= read_value_next;
      evicted     <= evicted_next;
      evicted_key <= evicted_key_next;
    end
  end

  // checks
  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_COMMIT))
    else $error("result strobe without a commit cycle");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> !hit)
    else $error("eviction reported on a hit");

  a_fill_in_capacity: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) <= 32'(capacity))
    else $error("more valid slots than capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !done))
    else $error("not busy after accepting a command");

endmodule

// ----- src/lfu_slot_store.sv -----
module lfu_slot_store (
  input  logic                      clk,
  input  lfu_pkg::slot_wr_t         wr,
  input  logic                      rd_en,
  input  logic [lfu_pkg::SLOT_W-1:0] rd_addr,
  output lfu_pkg::slot_t            rd_data
);
  import lfu_pkg::*;

  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] value_mem [ENTRIES];
  logic [COUNT_W-1:0]    count_mem [ENTRIES];
  logic [STAMP_W-1:0]    stamp_mem [ENTRIES];

  // write port: count and stamp go with every write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      count_mem[wr.addr] <= wr.data.count;
      stamp_mem[wr.addr] <= wr.data.stamp;
      if (wr.wr_key) begin
        key_mem[wr.addr] <= wr.data.key;
      end
      if (wr.wr_value) begin
        value_mem[wr.addr] <= wr.data.value;
      end
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.key   <= key_mem[rd_addr];
      rd_data.value <= value_mem[rd_addr];
      rd_data.count <= count_mem[rd_addr];
      rd_data.stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

// ----- src/lfu_scan_unit.sv -----
module lfu_scan_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         proc,
  input  logic [lfu_pkg::SLOT_W-1:0]   proc_idx,
  input  logic                         slot_ok,
  input  lfu_pkg::slot_t               rd,
  input  logic [lfu_pkg::KEY_BITS-1:0] req_key,
  input  logic [lfu_pkg::CNT_W-1:0]    capacity,
  input  logic [lfu_pkg::STAMP_W-1:0]  stamp_now,
  output lfu_pkg::scan_res_t           res
);
  import lfu_pkg::*;

  logic                  match_found;
  logic [SLOT_W-1:0]     match_idx;
  logic [COUNT_W-1:0]    match_count;
  logic [VALUE_BITS-1:0] match_value;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic [CNT_W-1:0]      used;
  logic                  victim_found;
  logic [SLOT_W-1:0]     victim_idx;
  logic [KEY_BITS-1:0]   victim_key;
  logic [COUNT_W-1:0]    best_cnt;
  logic [STAMP_W-1:0]    best_age;

  logic [STAMP_W-1:0] age;
  logic               take_match;
  logic               take_free;
  logic               take_victim;

  // one slot per cycle: key compare, free check, count/age compare
  always_comb begin
    age         = stamp_now - rd.stamp;
    take_match  = slot_ok && !match_found && (rd.key == req_key);
    take_free   = !slot_ok && !free_found && (CNT_W'(proc_idx) < capacity);
    take_victim = slot_ok && (!victim_found || (rd.count < best_cnt) ||
                  ((rd.count == best_cnt) && (age > best_age)));
  end

  // found flags and the valid count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      match_found  <= 1'b0;
      free_found   <= 1'b0;
      victim_found <= 1'b0;
      used         <= '0;
    end else if (proc) begin
      if (take_match) begin
        match_found <= 1'b1;
      end
      if (take_free) begin
        free_found <= 1'b1;
      end
      if (take_victim) begin
        victim_found <= 1'b1;
      end
      if (slot_ok) begin
        used <= used + CNT_W'(1);
      end
    end
  end

  // captured slot contents
  always_ff @(posedge clk) begin
    if (proc) begin
      if (take_match) begin
        match_idx   <= proc_idx;
        match_count <= rd.count;
        match_value <= rd.value;
      end
      if (take_free) begin
        free_idx <= proc_idx;
      end
      if (take_victim) begin
        victim_idx <= proc_idx;
        victim_key <= rd.key;
        best_cnt   <= rd.count;
        best_age   <= age;
      end
    end
  end

  assign res.match        = match_found;
  assign res.match_idx    = match_idx;
  assign res.match_count  = match_count;
  assign res.match_value  = match_value;
  assign res.free_found   = free_found;
  assign res.free_idx     = free_idx;
  assign res.used         = used;
  assign res.victim_found = victim_found;
  assign res.victim_idx   = victim_idx;
  assign res.victim_key   = victim_key;

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [PADDR_W-1:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = {~REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic        hit;
    logic [63:0] read_value;
    logic        evicted;
    logic [63:0] evicted_key;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic req_type;
  logic [FIELD_W-1:0] key;
  logic [FIELD_W-1:0] write_value;
  logic done;
  logic hit;
  logic [FIELD_W-1:0] read_value;
  logic evicted;
  logic [FIELD_W-1:0] evicted_key;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // shadow copy of the cache contents
  bit          slot_used [ENTRIES];
  logic [63:0] slot_tag  [ENTRIES];
  logic [63:0] slot_data [ENTRIES];
  logic [31:0] slot_uses [ENTRIES];
  logic [31:0] slot_stamp[ENTRIES];
  logic [31:0] stamp_next;
  int unsigned cap_now;

  outcome_t pending_outcomes[$];
  int mismatches = 0;
  int cycles = 0;
  bit steady = 1'b0;

  lfu_cache_lru_tiebreak dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .req_type(req_type), .key(key), .write_value(write_value),
    .done(done), .hit(hit), .read_value(read_value), .evicted(evicted),
    .evicted_key(evicted_key),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  // a slot enters a new use count and takes the next stamp
  function automatic void enter_count(int s, logic [31:0] c);
    slot_uses[s] = c;
    slot_stamp[s] = stamp_next;
    stamp_next = stamp_next + 32'd1;
  endfunction

  // one cache access: updates the shadow and returns what the block must report
  function automatic outcome_t cache_access(logic req, logic [63:0] k, logic [63:0] v);
    outcome_t o;
    int found;
    int target;
    int unsigned used;
    logic [31:0] best_cnt;
    logic [31:0] best_age;
    logic [31:0] age;
    o = '0;
    found = -1;
    target = -1;
    used = 0;
    best_cnt = '0;
    best_age = '0;
    if (cap_now == 0) return o;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_used[i] && slot_tag[i] == k) found = i;
    if (req == REQ_GET) begin
      if (found >= 0) begin
        o.hit = 1'b1;
        o.read_value = slot_data[found];
        if (slot_uses[found] != COUNT_MAX) enter_count(found, slot_uses[found] + 32'd1);
      end
    end else if (found >= 0) begin
      // update in place, count restarts
      o.hit = 1'b1;
      slot_data[found] = v;
      enter_count(found, 32'd1);
    end else begin
      for (int i = 0; i < ENTRIES; i++) if (slot_used[i]) used++;
      if (used >= cap_now) begin
        // lowest count, then oldest entry into that count, then lowest slot
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i]) begin
            age = stamp_next - slot_stamp[i];
            if (target < 0 || slot_uses[i] < best_cnt ||
                (slot_uses[i] == best_cnt && age > best_age)) begin
              target = i;
              best_cnt = slot_uses[i];
              best_age = age;
            end
          end
        end
        if (target >= 0) begin
          o.evicted = 1'b1;
          o.evicted_key = slot_tag[target];
          slot_used[target] = 1'b0;
        end
      end else begin
        for (int i = 0; i < cap_now && i < ENTRIES; i++)
          if (target < 0 && !slot_used[i]) target = i;
      end
      if (target >= 0) begin
        slot_used[target] = 1'b1;
        slot_tag[target] = k;
        slot_data[target] = v;
        enter_count(target, 32'd1);
      end
    end
    return o;
  endfunction

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("result with nothing pending", {63'd0, hit}, 64'd0);
      end else begin
        want = pending_outcomes.pop_front();
        if (hit !== want.hit) flag_mismatch("hit", {63'd0, hit}, {63'd0, want.hit});
        if (read_value !== want.read_value)
          flag_mismatch("read_value", read_value, want.read_value);
        if (evicted !== want.evicted)
          flag_mismatch("evicted", {63'd0, evicted}, {63'd0, want.evicted});
        if (evicted_key !== want.evicted_key)
          flag_mismatch("evicted_key", evicted_key, want.evicted_key);
      end
    end
  end

  // one command transfer; called and returns at a falling edge
  task automatic send_access(logic req, logic [63:0] k, logic [63:0] v);
    if (!steady && $urandom_range(99) < 31) begin
      start = 1'b0;
      key = {$urandom, $urandom};
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    start = 1'b1;
    req_type = req;
    key = k;
    write_value = v;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(cache_access(req, k, v));
    @(negedge clk);
    start = 1'b0;
  endtask

  // APB transfer: setup cycle, then access until pready
  task automatic apb_xfer(logic wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data,
                          output logic [PDATA_W-1:0] rdata);
    int unsigned raw;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr[2] == REG_CAPACITY) begin
      raw = 32'(data[CAP_RAW_W-1:0]);
      cap_now = (raw > ENTRIES) ? ENTRIES : raw;
      for (int i = cap_now; i < ENTRIES; i++) slot_used[i] = 1'b0;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] unused;
    apb_xfer(1'b1, addr, data, unused);
  endtask

  task automatic check_capacity();
    logic [PDATA_W-1:0] got;
    apb_xfer(1'b0, CAP_ADDR, {$urandom}, got);
    if (got !== cap_now) flag_mismatch("capacity readback", {32'd0, got}, {32'd0, cap_now});
  endtask

  // block idle: every result in, then a margin for the pipeline
  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (ENTRIES + 4) @(negedge clk);
  endtask

  // extreme keys and values, miss on empty cache, update in place
  task automatic test_extremes();
    check_capacity();
    send_access(REQ_GET, 64'd0, '1);
    send_access(REQ_SET, 64'd0, '1);
    send_access(REQ_SET, '1, 64'd0);
    send_access(REQ_GET, '1, 64'h5a5a_a5a5_5a5a_a5a5);
    send_access(REQ_GET, 64'd0, 64'd0);
    send_access(REQ_SET, 64'd0, 64'h0123_4567_89ab_cdef);
  endtask

  // least count goes first; equal counts lose the one that reached it earlier
  task automatic test_lfu_order();
    wait_drained();
    apb_write(CAP_ADDR, 32'd0);
    apb_write(CAP_ADDR, 32'd2);
    send_access(REQ_SET, 64'hAAAA_0000_0000_0001, 64'h11);
    send_access(REQ_SET, 64'hBBBB_0000_0000_0002, 64'h22);
    send_access(REQ_GET, 64'hAAAA_0000_0000_0001, 64'd0);
    send_access(REQ_SET, 64'hCCCC_0000_0000_0003, 64'h33);
    send_access(REQ_GET, 64'hCCCC_0000_0000_0003, 64'd0);
    send_access(REQ_SET, 64'hDDDD_0000_0000_0004, 64'h44);
    send_access(REQ_SET, 64'hEEEE_0000_0000_0005, 64'h55);
  endtask

  // capacity zero misses everything; capacity one; unused address leaves it alone
  task automatic test_disabled_cache();
    wait_drained();
    apb_write(CAP_ADDR, 32'd0);
    check_capacity();
    send_access(REQ_GET, 64'h7777_0000_0000_0007, 64'd0);
    send_access(REQ_SET, 64'h7777_0000_0000_0007, 64'h77);
    send_access(REQ_GET, 64'h7777_0000_0000_0007, 64'd0);
    wait_drained();
    apb_write(CAP_ADDR, 32'd1);
    apb_write(UNUSED_ADDR, 32'd0);
    check_capacity();
    send_access(REQ_SET, 64'h8888_0000_0000_0008, 64'h88);
    send_access(REQ_SET, 64'h9999_0000_0000_0009, 64'h99);
    send_access(REQ_GET, 64'h9999_0000_0000_0009, 64'd0);
  endtask

  // random accesses over a small key pool so hits and evictions are frequent
  task automatic test_random_phase(logic [PDATA_W-1:0] cap_raw, int n, int pool_n, bit calm);
    logic [63:0] pool[$];
    logic [63:0] k;
    wait_drained();
    apb_write(CAP_ADDR, cap_raw);
    check_capacity();
    steady = calm;
    repeat (pool_n) pool.push_back({$urandom, $urandom});
    repeat (n) begin
      if ($urandom_range(99) < 15) k = {$urandom, $urandom};
      else k = pool[$urandom_range(pool_n - 1)];
      send_access(($urandom_range(99) < 55) ? REQ_GET : REQ_SET, k, {$urandom, $urandom});
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_GET;
    key = '0;
    write_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
    stamp_next = '0;
    cap_now = CAP_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_lfu_order();
    test_disabled_cache();
    test_random_phase(32'd16, 200, 24, 1'b0);
    test_random_phase(32'hFFFF_FFE3, 90, 6, 1'b0);
    test_random_phase(32'd1, 60, 3, 1'b0);
    test_random_phase(32'd31, 150, 22, 1'b1);
    test_random_phase(32'd0, 25, 4, 1'b0);
    test_random_phase(32'd5, 90, 9, 1'b0);
    test_random_phase(32'd17, 80, 20, 1'b0);
    test_random_phase(32'd8, 90, 12, 1'b0);
    test_random_phase(32'd2, 65, 4, 1'b0);

    wait_drained();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
src/lfu_pkg.sv
src/lfu_slot_store.sv
src/lfu_scan_unit.sv
src/lfu_cache_lru_tiebreak.sv
bench/testbench.sv
